>>> src/gcdc_pkg.sv
// Package for the gear hash content-defined chunker.
// Holds the gear table, config types, cut cause and register index codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gcdc_pkg;

    localparam int PRINT_W         = 64;
    localparam int MASK_W          = 64;
    localparam int CFG_LEN_W       = 24;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int BYTE_W          = 8;
    localparam int GEAR_DEPTH      = 256;
    localparam int CAUSE_W         = 2;
    localparam int LEN_BITS_DEF    = 24;
    localparam int OFFSET_BITS_DEF = 48;

    localparam logic [PRINT_W-1:0] GEAR_SEED = 64'h1234_5678_9abc_def0;

    // Cut cause codes, as reported in the result
    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_STRICT  = 2'd0,
        CAUSE_RELAXED = 2'd1,
        CAUSE_MAX     = 2'd2,
        CAUSE_END     = 2'd3
    } t_cause;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_STRICT_MASK  = 3'd0,
        CFG_RELAXED_MASK = 3'd1,
        CFG_MIN_CHUNK    = 3'd2,
        CFG_AVG_CHUNK    = 3'd3,
        CFG_MAX_CHUNK    = 3'd4
    } t_cfg_idx;

    localparam logic [MASK_W-1:0]    STRICT_MASK_RST  = 64'hFFFF;
    localparam logic [MASK_W-1:0]    RELAXED_MASK_RST = 64'hFFF;
    localparam logic [CFG_LEN_W-1:0] MIN_CHUNK_RST    = 24'd2048;
    localparam logic [CFG_LEN_W-1:0] AVG_CHUNK_RST    = 24'd8192;
    localparam logic [CFG_LEN_W-1:0] MAX_CHUNK_RST    = 24'd65536;

    // Configuration as seen by the cut logic
    typedef struct packed {
        logic [MASK_W-1:0]    strict_mask;
        logic [MASK_W-1:0]    relaxed_mask;
        logic [CFG_LEN_W-1:0] min_chunk;
        logic [CFG_LEN_W-1:0] avg_chunk;
        logic [CFG_LEN_W-1:0] max_chunk;
    } t_cfg;

    // One byte after the table lookup
    typedef struct packed {
        logic [PRINT_W-1:0] gear;
        logic               last;
    } t_item;

    typedef logic [GEAR_DEPTH-1:0][PRINT_W-1:0] t_gear_tab;

    // Fill the gear table by xorshift 13/7/17; evaluated at elaboration only
    function automatic t_gear_tab build_gear();
        logic [PRINT_W-1:0] v;
        t_gear_tab          tab;
        v = GEAR_SEED;
        for (int k = 0; k < GEAR_DEPTH; k++) begin
            v = v ^ (v << 13);
            v = v ^ (v >> 7);
            v = v ^ (v << 17);
            tab[k] = v;
        end
        return tab;
    endfunction

    localparam t_gear_tab GEAR_TAB = build_gear();

endpackage

`default_nettype wire

>>> src/gcdc_cfg_regs.sv
// Configuration registers of the chunker: masks and chunk size limits.
// Depends on gcdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcdc_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [gcdc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [gcdc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output gcdc_pkg::t_cfg                     o_cfg
);
    import gcdc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write index; unused indexes drop the write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_STRICT_MASK:  n_cfg.strict_mask  = i_cfg_wdata[MASK_W-1:0];
                CFG_RELAXED_MASK: n_cfg.relaxed_mask = i_cfg_wdata[MASK_W-1:0];
                CFG_MIN_CHUNK:    n_cfg.min_chunk    = i_cfg_wdata[CFG_LEN_W-1:0];
                CFG_AVG_CHUNK:    n_cfg.avg_chunk    = i_cfg_wdata[CFG_LEN_W-1:0];
                CFG_MAX_CHUNK:    n_cfg.max_chunk    = i_cfg_wdata[CFG_LEN_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strict_mask  <= STRICT_MASK_RST;
            r_cfg.relaxed_mask <= RELAXED_MASK_RST;
            r_cfg.min_chunk    <= MIN_CHUNK_RST;
            r_cfg.avg_chunk    <= AVG_CHUNK_RST;
            r_cfg.max_chunk    <= MAX_CHUNK_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> src/gcdc_in_stage.sv
// Input register of the chunker; looks up the gear value of each byte on entry.
// Depends on gcdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcdc_in_stage (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output      logic                      o_ready,
    input  wire logic [gcdc_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                      i_last,
    output      logic                      o_valid,
    output gcdc_pkg::t_item                o_item,
    input  wire logic                      i_take
);
    import gcdc_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  n_valid;
    logic  load;

    // Refill when empty or when the held byte moves on this cycle
    assign o_ready = !r_valid || i_take;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload: gear table read and last flag
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.gear <= GEAR_TAB[i_byte];
            r_item.last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

>>> src/gcdc_cut_core.sv
// Fingerprint update, chunk length and offset counters, cut decision and
// result register. Depends on gcdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcdc_cut_core #(
    parameter int LEN_BITS    = gcdc_pkg::LEN_BITS_DEF,
    parameter int OFFSET_BITS = gcdc_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire gcdc_pkg::t_cfg               i_cfg,
    input  wire logic                         i_valid,
    input  wire gcdc_pkg::t_item              i_item,
    output      logic                         o_take,
    output      logic                         o_valid,
    input  wire logic                         i_ready,
    output      logic [OFFSET_BITS-1:0]       o_offset,
    output      logic [gcdc_pkg::CFG_LEN_W-1:0] o_length,
    output      logic [gcdc_pkg::CAUSE_W-1:0]   o_cause
);
    import gcdc_pkg::*;

    localparam int CMP_W = (LEN_BITS > CFG_LEN_W) ? LEN_BITS : CFG_LEN_W;

    logic [PRINT_W-1:0]     r_print;
    logic [LEN_BITS-1:0]    r_count;
    logic [OFFSET_BITS-1:0] r_offset;
    logic                   r_out_valid;
    logic [OFFSET_BITS-1:0] r_out_offset;
    logic [CFG_LEN_W-1:0]   r_out_len;
    t_cause                 r_out_cause;

    logic [PRINT_W-1:0]     n_print;
    logic [LEN_BITS-1:0]    n_count;
    logic [OFFSET_BITS-1:0] n_offset;
    logic [CMP_W-1:0]       len_ext;
    logic                   cut;
    t_cause                 cause;

    // Move the held byte on when the result slot is free or being emptied
    assign o_take = i_valid && (!r_out_valid || i_ready);

    // Shift-add, saturating counters and cut decision by priority
    always_comb begin
        n_print  = (r_print << 1) + i_item.gear;
        n_count  = (r_count == '1) ? r_count : r_count + 1'b1;
        n_offset = (r_offset == '1) ? r_offset : r_offset + 1'b1;
        len_ext  = CMP_W'(n_count);
        cut      = 1'b0;
        cause    = CAUSE_END;
        if (len_ext > CMP_W'(i_cfg.min_chunk)) begin
            if (len_ext <= CMP_W'(i_cfg.avg_chunk)) begin
                if ((n_print & i_cfg.strict_mask) == '0) begin
                    cut   = 1'b1;
                    cause = CAUSE_STRICT;
                end
            end else if ((n_print & i_cfg.relaxed_mask) == '0) begin
                cut   = 1'b1;
                cause = CAUSE_RELAXED;
            end
        end
        if (!cut && (len_ext >= CMP_W'(i_cfg.max_chunk) || n_count == '1)) begin
            cut   = 1'b1;
            cause = CAUSE_MAX;
        end
        if (!cut && i_item.last) begin
            cut   = 1'b1;
            cause = CAUSE_END;
        end
    end

    // Chunk state: restart fingerprint and length at each cut
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_print  <= '0;
            r_count  <= '0;
            r_offset <= '0;
        end else if (o_take) begin
            r_offset <= n_offset;
            if (cut) begin
                r_print <= '0;
                r_count <= '0;
            end else begin
                r_print <= n_print;
                r_count <= n_count;
            end
        end
    end

    // Result register: hold until the downstream transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && cut) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && cut) begin
            r_out_offset <= n_offset;
            r_out_len    <= len_ext[CFG_LEN_W-1:0];
            r_out_cause  <= cause;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_offset = r_out_offset;
    assign o_length = r_out_len;
    assign o_cause  = r_out_cause;

    // The length counter never rests at its ceiling: that length always cuts
    a_count_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '1)
        else $error("chunk length counter reached its ceiling");

    // A cut restarts fingerprint and length
    a_cut_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && cut) |=> (r_print == '0 && r_count == '0))
        else $error("chunk state not restarted after cut");

    // Every byte moves the offset off zero
    a_offset_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> r_offset != '0)
        else $error("stream offset did not advance");

    // A new result only loads into a free or draining slot
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !o_take)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

>>> src/gear_hash_content_defined_chunker_unit.sv
// Gear hash content-defined chunker, top level.
// A result passes the input register and then the result register before it appears.
// Throughput: one byte per cycle while no held result stalls; set by the loop
// through the fingerprint shift-add, the length counter and the mask test.
// Synchronous active-low reset clears chunk state and offset and loads the
// default masks and chunk sizes. Depends on gcdc_pkg and the gcdc_* modules.
`timescale 1ns / 1ps
`default_nettype none

module gear_hash_content_defined_chunker_unit #(
    parameter int LEN_BITS    = gcdc_pkg::LEN_BITS_DEF,
    parameter int OFFSET_BITS = gcdc_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Configuration writes
    input  wire logic                           i_cfg_we,
    input  wire logic [gcdc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [gcdc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // Byte stream in
    input  wire logic                           s_axis_tvalid,
    output      logic                           s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
    input  wire logic                           s_axis_tlast,  // final_byte
    // Cut results out
    output      logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // cut_offset [OFFSET_BITS-1:0], chunk_length next 24 bits, zero padded
    output      logic [((OFFSET_BITS + gcdc_pkg::CFG_LEN_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output      logic [gcdc_pkg::CAUSE_W-1:0]     m_axis_tuser   // [1:0] cut_cause
);
    import gcdc_pkg::*;

    localparam int OUT_TDATA_W = ((OFFSET_BITS + CFG_LEN_W + 7) / 8) * 8;

    t_cfg                   cfg;
    t_item                  item;
    logic                   item_valid;
    logic                   take;
    logic [OFFSET_BITS-1:0] out_offset;
    logic [CFG_LEN_W-1:0]   out_len;

    gcdc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    gcdc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata[BYTE_W-1:0]),
        .i_last  (s_axis_tlast),
        .o_valid (item_valid),
        .o_item  (item),
        .i_take  (take)
    );

    gcdc_cut_core #(
        .LEN_BITS    (LEN_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (item_valid),
        .i_item   (item),
        .o_take   (take),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_offset (out_offset),
        .o_length (out_len),
        .o_cause  (m_axis_tuser)
    );

    // Pack result fields, offset in the low bits
    assign m_axis_tdata = OUT_TDATA_W'({out_len, out_offset});

endmodule

`default_nettype wire
